// ===== design/scd_pkg.sv =====
`default_nettype none

package scd_pkg;

	// Directory geometry
	localparam int ENTRIES     = 64;
	localparam int SECTOR_BITS = 32;
	localparam int SLOT_W      = $clog2(ENTRIES);
	localparam int CNT_W       = $clog2(ENTRIES + 1);

	typedef logic [SLOT_W-1:0]      slot_t;
	typedef logic [ENTRIES-1:0]     vec_t;
	typedef logic [SECTOR_BITS-1:0] tag_t;
	typedef logic [CNT_W-1:0]       cnt_t;

	// Request operation codes
	typedef enum logic [1:0] {
		OP_READ  = 2'd0,
		OP_WRITE = 2'd1,
		OP_FLUSH = 2'd2
	} op_t;

	// Result kinds
	typedef enum logic [2:0] {
		KIND_HIT   = 3'd0,
		KIND_FILL  = 3'd1,
		KIND_EVICT = 3'd2,
		KIND_FLUSH = 3'd3,
		KIND_CLEAN = 3'd4
	} kind_t;

	// Commands from controller to datapath
	typedef struct packed {
		logic capture;    // latch the request
		logic lookup;     // register the tag match vector
		logic decide;     // pick the slot and kind, age accessed bits
		logic update;     // write the directory and load the result
		logic fl_find;    // pick the lowest dirty slot
		logic fl_emit;    // emit one flush result and clean the slot
		logic none_emit;  // emit the nothing-dirty result
	} cmd_t;

	// Status from datapath to controller
	typedef struct packed {
		logic out_free;   // output register can take a result this cycle
		logic fl_any;     // some slot is dirty
		logic fl_more;    // another dirty slot remains besides the chosen one
	} stat_t;

	// Index of the lowest set bit, zero when none is set
	function automatic slot_t first_set(input vec_t v);
		slot_t idx;
		idx = '0;
		for (int i = ENTRIES - 1; i >= 0; i--) begin
			if (v[i]) begin
				idx = slot_t'(i);
			end
		end
		return idx;
	endfunction

endpackage

`default_nettype wire

// ===== design/scd_ctrl.sv =====
`default_nettype none

module scd_ctrl (
	input  wire logic          clk,
	input  wire logic          arst_n,
	input  wire logic          in_valid,
	output logic               in_ready,
	input  wire scd_pkg::op_t  in_op,
	input  wire scd_pkg::stat_t stat,
	output scd_pkg::cmd_t      cmd
);
	import scd_pkg::*;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_LOOKUP,
		ST_DECIDE,
		ST_UPDATE,
		ST_FL_FIND,
		ST_FL_EMIT
	} state_t;

	state_t state_q;
	logic   accept;

	assign in_ready = (state_q == ST_IDLE);
	assign accept   = in_valid && in_ready;

	// Issue datapath commands for the current step
	always_comb begin
		cmd           = '0;
		cmd.capture   = accept;
		cmd.lookup    = (state_q == ST_LOOKUP);
		cmd.decide    = (state_q == ST_DECIDE);
		cmd.update    = (state_q == ST_UPDATE) && stat.out_free;
		cmd.fl_find   = (state_q == ST_FL_FIND) && stat.fl_any;
		cmd.none_emit = (state_q == ST_FL_FIND) && !stat.fl_any && stat.out_free;
		cmd.fl_emit   = (state_q == ST_FL_EMIT) && stat.out_free;
	end

	// Advance the sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (accept) begin
						unique case (in_op)
							OP_READ, OP_WRITE: state_q <= ST_LOOKUP;
							OP_FLUSH:          state_q <= ST_FL_FIND;
							default:           state_q <= ST_IDLE;
						endcase
					end
				end
				ST_LOOKUP: state_q <= ST_DECIDE;
				ST_DECIDE: state_q <= ST_UPDATE;
				ST_UPDATE: begin
					if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FL_FIND: begin
					if (stat.fl_any) begin
						state_q <= ST_FL_EMIT;
					end else if (stat.out_free) begin
						state_q <= ST_IDLE;
					end
				end
				ST_FL_EMIT: begin
					if (stat.out_free) begin
						state_q <= stat.fl_more ? ST_FL_FIND : ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// ===== design/scd_dpath.sv =====
`default_nettype none

module scd_dpath (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire scd_pkg::cmd_t           cmd,
	output scd_pkg::stat_t               stat,
	input  wire scd_pkg::op_t            in_op,
	input  wire logic [31:0]             in_sector,
	output logic                         out_valid,
	input  wire logic                    out_ready,
	output scd_pkg::kind_t               out_kind,
	output logic [5:0]                   out_slot,
	output logic [31:0]                  out_victim,
	output logic                         out_wb,
	output logic                         out_last
);
	import scd_pkg::*;

	// Directory state
	tag_t  tag_q [ENTRIES];
	vec_t  valid_q;
	vec_t  acc_q;
	vec_t  dirty_q;
	cnt_t  fill_q;

	// Request and working registers
	op_t   op_q;
	tag_t  sector_q;
	vec_t  match_s1;
	slot_t slot_q;
	kind_t kind_q;

	// Output register
	logic  out_valid_q;
	kind_t out_kind_q;
	slot_t out_slot_q;
	tag_t  out_victim_q;
	logic  out_wb_q;
	logic  out_last_q;

	logic  out_free;
	logic  full;
	vec_t  not_acc;
	vec_t  acc_low;
	vec_t  acc_clear;
	vec_t  sel_mask;
	tag_t  sel_tag;
	logic  sel_dirty;

	assign out_free = !out_valid_q || out_ready;
	assign full     = (fill_q == cnt_t'(ENTRIES));

	// Second-chance aging: clear every accessed bit below the victim, all if none
	assign not_acc   = ~acc_q;
	assign acc_low   = not_acc & (~not_acc + vec_t'(1));
	assign acc_clear = (|not_acc) ? (acc_low - vec_t'(1)) : '1;

	// Read the chosen slot
	assign sel_tag   = tag_q[slot_q];
	assign sel_dirty = dirty_q[slot_q];
	assign sel_mask  = vec_t'(1) << slot_q;

	assign stat.out_free = out_free;
	assign stat.fl_any   = |dirty_q;
	assign stat.fl_more  = |(dirty_q & ~sel_mask);

	// Latch the request, register the parallel tag compare, pick the slot and write the tag
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= in_op;
			sector_q <= in_sector;
		end
		if (cmd.lookup) begin
			for (int i = 0; i < ENTRIES; i++) begin
				match_s1[i] <= valid_q[i] && (tag_q[i] == sector_q);
			end
		end
		if (cmd.decide) begin
			if (|match_s1) begin
				slot_q <= first_set(match_s1);
				kind_q <= KIND_HIT;
			end else if (!full) begin
				slot_q <= first_set(~valid_q);
				kind_q <= KIND_FILL;
			end else begin
				slot_q <= first_set(not_acc);
				kind_q <= KIND_EVICT;
			end
		end
		if (cmd.fl_find) begin
			slot_q <= first_set(dirty_q);
		end
		if (cmd.update && (kind_q != KIND_HIT)) begin
			tag_q[slot_q] <= sector_q;
		end
	end

	// Update status bits and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			acc_q   <= '0;
			dirty_q <= '0;
			fill_q  <= '0;
		end else begin
			if (cmd.decide && !(|match_s1) && full) begin
				acc_q <= acc_q & ~acc_clear;
			end
			if (cmd.update) begin
				if (kind_q == KIND_HIT) begin
					if (op_q == OP_WRITE) begin
						dirty_q[slot_q] <= 1'b1;
					end else begin
						acc_q[slot_q] <= 1'b1;
					end
				end else begin
					valid_q[slot_q] <= 1'b1;
					acc_q[slot_q]   <= (op_q != OP_WRITE);
					dirty_q[slot_q] <= (op_q == OP_WRITE);
					if (kind_q == KIND_FILL) begin
						fill_q <= fill_q + cnt_t'(1);
					end
				end
			end
			if (cmd.fl_emit) begin
				dirty_q[slot_q] <= 1'b0;
			end
		end
	end

	// Hold the result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.update || cmd.fl_emit || cmd.none_emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Load the result payload
	always_ff @(posedge clk) begin
		if (cmd.update) begin
			out_kind_q   <= kind_q;
			out_slot_q   <= slot_q;
			out_victim_q <= (kind_q == KIND_EVICT) ? sel_tag : '0;
			out_wb_q     <= (kind_q == KIND_EVICT) && sel_dirty;
			out_last_q   <= 1'b1;
		end else if (cmd.fl_emit) begin
			out_kind_q   <= KIND_FLUSH;
			out_slot_q   <= slot_q;
			out_victim_q <= sel_tag;
			out_wb_q     <= 1'b1;
			out_last_q   <= !stat.fl_more;
		end else if (cmd.none_emit) begin
			out_kind_q   <= KIND_CLEAN;
			out_slot_q   <= '0;
			out_victim_q <= '0;
			out_wb_q     <= 1'b0;
			out_last_q   <= 1'b1;
		end
	end

	assign out_valid  = out_valid_q;
	assign out_kind   = out_kind_q;
	assign out_slot   = out_slot_q;
	assign out_victim = out_victim_q;
	assign out_wb     = out_wb_q;
	assign out_last   = out_last_q;

endmodule

`default_nettype wire

// ===== design/sector_cache_directory.sv =====
`default_nettype none

// Tag directory of a 64-slot fully associative disk-sector cache with
// second-chance replacement. Each item on the slave stream is a read, a write
// or a flush. A read or write puts its single result in the output register
// through these steps: the accepting edge latches the request, then the
// registered parallel compare against all 64 tags, the priority encoders that
// pick the hit, empty or victim slot (and age the accessed bits), and the
// update of the directory and load of the output register. A flush gives one
// result per dirty slot (lowest-dirty-slot encoder, then tag read), or one
// nothing-dirty result from the find step. A result still waiting in the
// output register holds the update or emit step until it is taken. One
// request is in work at a time; the next is taken once the last result of
// the current one is in the output register. No clearing pass is needed
// after reset.
module sector_cache_directory (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [31:0] s_tdata,   // [31:0] sector
	input  wire logic [1:0]  s_tuser,   // [1:0] op
	output logic             m_tvalid,
	input  wire logic        m_tready,
	output logic [39:0]      m_tdata,   // [5:0] slot, [37:6] victim_sector, [38] writeback, [39] zero
	output logic [2:0]       m_tuser,   // [2:0] kind
	output logic             m_tlast
);
	import scd_pkg::*;

	cmd_t        cmd;
	stat_t       stat;
	op_t         in_op;
	kind_t       out_kind;
	logic [5:0]  out_slot;
	logic [31:0] out_victim;
	logic        out_wb;

	assign in_op = op_t'(s_tuser);

	scd_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (s_tvalid),
		.in_ready (s_tready),
		.in_op    (in_op),
		.stat     (stat),
		.cmd      (cmd)
	);

	scd_dpath u_dpath (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd        (cmd),
		.stat       (stat),
		.in_op      (in_op),
		.in_sector  (s_tdata),
		.out_valid  (m_tvalid),
		.out_ready  (m_tready),
		.out_kind   (out_kind),
		.out_slot   (out_slot),
		.out_victim (out_victim),
		.out_wb     (out_wb),
		.out_last   (m_tlast)
	);

	// Pack the result item
	assign m_tdata = {1'b0, out_wb, out_victim, out_slot};
	assign m_tuser = out_kind;

endmodule

`default_nettype wire

// ===== tb/tb_sector_cache_directory.sv =====
`default_nettype none

module tb_sector_cache_directory;
	timeunit 1ns;
	timeprecision 1ps;

	import scd_pkg::*;

	// Opcode with no defined meaning; the block must ignore it
	localparam logic [1:0] OP_NONE = 2'd3;
	localparam int POOL_N = 96;

	// One expected item on the master side
	typedef struct packed {
		kind_t       kind;
		slot_t       slot;
		logic [31:0] victim;
		logic        wb;
		logic        last;
	} dir_result_t;

	// One row of the directed table
	typedef struct {
		logic [1:0]  op;
		logic [31:0] sector;
		bit          typed;
		dir_result_t want;
	} dir_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [31:0] s_tdata = '0;
	logic [1:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [2:0]  m_tuser;
	logic        m_tlast;

	sector_cache_directory u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tlast  (m_tlast)
	);

	// Directory shadow state
	tag_t dir_tag [ENTRIES];
	vec_t dir_valid;
	vec_t dir_accessed;
	vec_t dir_dirty;
	cnt_t dir_fill;

	dir_result_t pending_results[$];
	dir_row_t    directed_rows[$];
	logic [31:0] sector_pool [POOL_N];
	dir_result_t blank;
	dir_result_t got_exp;

	int errors = 0;
	int src_idle = 6;
	int dst_idle = 48;
	int stall_req = 0;
	int hold_left = 0;

	always #5 clk = ~clk;

	initial begin
		#10ms;
		$display("FAILED: results differ");
		$finish;
	end

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("MISMATCH %s: got %0h expected %0h at %0t", what, got, want, $realtime);
		errors++;
	endtask

	// Advance the shadow directory by one request and queue its results
	task automatic directory_step(input logic [1:0] op, input logic [31:0] sector,
			input bit push);
		dir_result_t r;
		int hit;
		int pick;
		int n;
		bit is_wr;
		hit = -1;
		pick = -1;
		n = 0;
		is_wr = (op == OP_WRITE);
		r = '{KIND_HIT, slot_t'(0), 32'h0, 1'b0, 1'b1};
		case (op)
			OP_FLUSH: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (dir_dirty[i]) begin
						r = '{KIND_FLUSH, slot_t'(i), dir_tag[i], 1'b1, 1'b0};
						dir_dirty[i] = 1'b0;
						if (push) pending_results.push_back(r);
						n++;
					end
				end
				if (n == 0) begin
					r = '{KIND_CLEAN, slot_t'(0), 32'h0, 1'b0, 1'b1};
					if (push) pending_results.push_back(r);
				end else if (push) begin
					pending_results[$].last = 1'b1;
				end
			end
			OP_READ, OP_WRITE: begin
				for (int i = 0; i < ENTRIES; i++) begin
					if (hit < 0 && dir_valid[i] && dir_tag[i] == sector) hit = i;
				end
				if (hit >= 0) begin
					if (is_wr) dir_dirty[hit] = 1'b1;
					else dir_accessed[hit] = 1'b1;
					r.slot = slot_t'(hit);
				end else begin
					for (int i = 0; i < ENTRIES; i++) begin
						if (pick < 0 && !dir_valid[i]) pick = i;
					end
					if (pick >= 0) begin
						r.kind = KIND_FILL;
						if (dir_fill < ENTRIES) dir_fill++;
					end else begin
						// Second chance: clear set bits until a clear one turns up
						for (int i = 0; i < ENTRIES; i++) begin
							if (pick < 0) begin
								if (!dir_accessed[i]) pick = i;
								else dir_accessed[i] = 1'b0;
							end
						end
						if (pick < 0) pick = 0;
						r.kind = KIND_EVICT;
						r.victim = dir_tag[pick];
						r.wb = dir_dirty[pick];
					end
					dir_tag[pick] = sector;
					dir_valid[pick] = 1'b1;
					dir_accessed[pick] = !is_wr;
					dir_dirty[pick] = is_wr;
					r.slot = slot_t'(pick);
				end
				if (push) pending_results.push_back(r);
			end
			default: ;
		endcase
	endtask

	// Offer one item, hold it until accepted, then predict
	task automatic send_item(input logic [1:0] op, input logic [31:0] sector,
			input bit typed, input dir_result_t want);
		if ($urandom_range(99) < src_idle) begin
			s_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < src_idle);
		end
		s_tvalid <= 1'b1;
		s_tdata <= sector;
		s_tuser <= op;
		do @(posedge clk); while (!s_tready);
		directory_step(op, sector, !typed);
		if (typed) pending_results.push_back(want);
	endtask

	function automatic logic [31:0] pick_sector();
		int r;
		r = $urandom_range(99);
		if (r < 75) return sector_pool[$urandom_range(POOL_N - 1)];
		if (r < 90) return $urandom();
		case ($urandom_range(3))
			0: return 32'h0;
			1: return 32'hFFFF_FFFF;
			2: return 32'h1 << $urandom_range(31);
			default: return ~(32'h1 << $urandom_range(31));
		endcase
	endfunction

	// Mixed random traffic; ignored opcodes do not count
	task automatic send_random(input int count);
		int sent;
		int r;
		logic [1:0] op;
		sent = 0;
		while (sent < count) begin
			r = $urandom_range(99);
			if (r < 48) op = OP_READ;
			else if (r < 88) op = OP_WRITE;
			else if (r < 96) op = OP_FLUSH;
			else op = OP_NONE;
			send_item(op, pick_sector(), 1'b0, blank);
			if (op != OP_NONE) sent++;
		end
	endtask

	// Fill the cache, touch every slot, then miss so the scan wraps to slot 0
	task automatic age_all_slots();
		while (dir_fill < ENTRIES) send_item(OP_READ, $urandom(), 1'b0, blank);
		for (int i = 0; i < ENTRIES; i++) send_item(OP_READ, dir_tag[i], 1'b0, blank);
		send_item(OP_WRITE, $urandom(), 1'b0, blank);
	endtask

	// Dirty every held slot, then flush them all in one request
	task automatic dirty_all_slots();
		for (int i = 0; i < ENTRIES; i++) begin
			if (dir_valid[i]) send_item(OP_WRITE, dir_tag[i], 1'b0, blank);
		end
		send_item(OP_FLUSH, $urandom(), 1'b0, blank);
	endtask

	// Check each accepted result and drive the ready side
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tready <= 1'b0;
		end else begin
			if (m_tvalid && m_tready) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with none outstanding", {29'h0, m_tuser}, 32'h0);
				end else begin
					got_exp = pending_results.pop_front();
					if (m_tuser !== got_exp.kind)
						report_mismatch("kind", {29'h0, m_tuser}, {29'h0, got_exp.kind});
					if (m_tdata[5:0] !== got_exp.slot)
						report_mismatch("slot", {26'h0, m_tdata[5:0]}, {26'h0, got_exp.slot});
					if (m_tdata[37:6] !== got_exp.victim)
						report_mismatch("victim_sector", m_tdata[37:6], got_exp.victim);
					if (m_tdata[38] !== got_exp.wb)
						report_mismatch("writeback", {31'h0, m_tdata[38]}, {31'h0, got_exp.wb});
					if (m_tlast !== got_exp.last)
						report_mismatch("last", {31'h0, m_tlast}, {31'h0, got_exp.last});
				end
			end
			if (stall_req > 0) begin
				hold_left = stall_req;
				stall_req = 0;
			end
			if (hold_left > 0) begin
				hold_left--;
				m_tready <= 1'b0;
			end else begin
				m_tready <= ($urandom_range(99) >= dst_idle);
			end
		end
	end

	initial begin
		int waited;
		blank = '{KIND_HIT, slot_t'(0), 32'h0, 1'b0, 1'b0};
		dir_valid = '0;
		dir_accessed = '0;
		dir_dirty = '0;
		dir_fill = '0;
		for (int i = 0; i < ENTRIES; i++) dir_tag[i] = '0;
		for (int i = 0; i < POOL_N; i++) sector_pool[i] = $urandom();

		// Directed rows: extremes, every opcode, write and read hits, empty flush
		directed_rows.push_back('{OP_FLUSH, 32'h0, 1'b1,
			'{KIND_CLEAN, slot_t'(0), 32'h0, 1'b0, 1'b1}});
		directed_rows.push_back('{OP_READ, 32'h0, 1'b1,
			'{KIND_FILL, slot_t'(0), 32'h0, 1'b0, 1'b1}});
		directed_rows.push_back('{OP_WRITE, 32'hFFFF_FFFF, 1'b1,
			'{KIND_FILL, slot_t'(1), 32'h0, 1'b0, 1'b1}});
		directed_rows.push_back('{OP_READ, 32'h0, 1'b1,
			'{KIND_HIT, slot_t'(0), 32'h0, 1'b0, 1'b1}});
		directed_rows.push_back('{OP_WRITE, 32'hFFFF_FFFF, 1'b1,
			'{KIND_HIT, slot_t'(1), 32'h0, 1'b0, 1'b1}});
		directed_rows.push_back('{OP_READ, 32'hFFFF_FFFF, 1'b1,
			'{KIND_HIT, slot_t'(1), 32'h0, 1'b0, 1'b1}});
		directed_rows.push_back('{OP_NONE, 32'h1234_5678, 1'b0, blank});
		directed_rows.push_back('{OP_WRITE, 32'h0, 1'b1,
			'{KIND_HIT, slot_t'(0), 32'h0, 1'b0, 1'b1}});
		directed_rows.push_back('{OP_FLUSH, 32'hFFFF_FFFF, 1'b0, blank});
		directed_rows.push_back('{OP_FLUSH, 32'h0, 1'b1,
			'{KIND_CLEAN, slot_t'(0), 32'h0, 1'b0, 1'b1}});
		directed_rows.push_back('{OP_WRITE, 32'h8000_0001, 1'b1,
			'{KIND_FILL, slot_t'(2), 32'h0, 1'b0, 1'b1}});
		directed_rows.push_back('{OP_READ, 32'h7FFF_FFFE, 1'b1,
			'{KIND_FILL, slot_t'(3), 32'h0, 1'b0, 1'b1}});
		directed_rows.push_back('{OP_READ, 32'h8000_0001, 1'b1,
			'{KIND_HIT, slot_t'(2), 32'h0, 1'b0, 1'b1}});
		directed_rows.push_back('{OP_FLUSH, 32'hFFFF_FFFF, 1'b1,
			'{KIND_FLUSH, slot_t'(2), 32'h8000_0001, 1'b1, 1'b1}});
		directed_rows.push_back('{OP_WRITE, 32'h0000_0001, 1'b0, blank});
		directed_rows.push_back('{OP_READ, 32'hAAAA_AAAA, 1'b0, blank});
		directed_rows.push_back('{OP_WRITE, 32'h5555_5555, 1'b0, blank});
		directed_rows.push_back('{OP_NONE, 32'hFFFF_FFFF, 1'b0, blank});
		directed_rows.push_back('{OP_FLUSH, 32'h0, 1'b0, blank});

		// Hold reset, then release on an edge
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Sender mostly busy, receiver idles often
		src_idle = 6;
		dst_idle = 48;
		foreach (directed_rows[i])
			send_item(directed_rows[i].op, directed_rows[i].sector,
				directed_rows[i].typed, directed_rows[i].want);
		send_random(70);
		age_all_slots();
		send_random(20);

		// Sender idles often, receiver mostly ready
		src_idle = 48;
		dst_idle = 6;
		send_random(70);

		// No idling; drain, then stall the receiver while items keep coming
		src_idle = 0;
		dst_idle = 0;
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		stall_req = 400;
		send_random(40);
		dirty_all_slots();
		send_random(30);

		// Wait for the last results, then a few more cycles for strays
		s_tvalid <= 1'b0;
		waited = 0;
		while (pending_results.size() != 0 && waited < 200000) begin
			@(posedge clk);
			waited++;
		end
		repeat (40) @(posedge clk);
		if (pending_results.size() != 0)
			report_mismatch("results never produced", 32'h0, pending_results.size());
		if (errors == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

`default_nettype wire
